// ===== src/hamming_near_duplicate_tile_table_macros.svh =====
// ----------------------------------------------------------------------------
// Tile table assertion macros
// Assertion macros shared by the tile table RTL.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the including module.
`ifndef HAMMING_NEAR_DUPLICATE_TILE_TABLE_MACROS_SVH
`define HAMMING_NEAR_DUPLICATE_TILE_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HNDT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HNDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hndt_pkg.sv =====
// ----------------------------------------------------------------------------
// Tile table package
// Shared constants, the cell control struct and the tile distance function.
// ----------------------------------------------------------------------------
package hndt_pkg;

    localparam int TILE_W   = 64;
    localparam int DIST_W   = 7;
    localparam int THRESH_W = 7;
    localparam int SLOT_W   = 6;
    localparam int UCOUNT_W = 7;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd8;
    localparam logic [3:0]          NIBBLE_MASK  = 4'h0F;
    localparam int                  TILE_BYTES   = 8;

    localparam logic [2:0] NIBBLE_ONES [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic capture;  // latch the distance to the incoming tile
        logic append;   // store the held tile in the first free cell
    } cell_ctl_t;

    // Number of differing bits between two tiles, summed as a small tree.
    function automatic logic [DIST_W-1:0] tile_distance(
        input logic [TILE_W-1:0] a,
        input logic [TILE_W-1:0] b
    );
        logic [TILE_W-1:0] x;
        logic [3:0]        byte_w [TILE_BYTES];
        logic [4:0]        quad_w [TILE_BYTES/2];
        logic [5:0]        half_w [TILE_BYTES/4];
        x = a ^ b;
        for (int i = 0; i < TILE_BYTES; i++) begin
            byte_w[i] = {1'b0, NIBBLE_ONES[x[8*i +: 4] & NIBBLE_MASK]}
                      + {1'b0, NIBBLE_ONES[x[8*i+4 +: 4] & NIBBLE_MASK]};
        end
        for (int i = 0; i < TILE_BYTES/2; i++) begin
            quad_w[i] = {1'b0, byte_w[2*i]} + {1'b0, byte_w[2*i+1]};
        end
        for (int i = 0; i < TILE_BYTES/4; i++) begin
            half_w[i] = {1'b0, quad_w[2*i]} + {1'b0, quad_w[2*i+1]};
        end
        return {1'b0, half_w[0]} + {1'b0, half_w[1]};
    endfunction

endpackage

// ===== src/hamming_near_duplicate_tile_table.sv =====
// ----------------------------------------------------------------------------
// Near-duplicate tile table
// Matches 8x8 bitmap tiles against a table of unique tiles by bit distance.
// ----------------------------------------------------------------------------
// Usage:
//   Present a tile on tile_bits and raise start; the transfer happens at a
//   clock edge where start is high and busy is low. busy stays high for the
//   one cycle in which the table decides on the tile.
//   Exactly one result follows each tile: done is high for one cycle,
//   registered from the decide state, together with is_new, slot,
//   match_distance, unique_count and table_full.
//   A new tile can be taken in the same cycle in which done is high, but
//   not while the last one is being decided. Each cell registers its distance
//   to the tile at the input transfer; the priority chain across the cells
//   and the append into the first free cell finish in the decide cycle.
//   The receiver cannot stall; done is a one-cycle strobe.
//   cfg_write loads the match threshold from cfg_data; write it only while
//   idle. Reset empties the table (fill count zero, no clearing pass) and
//   sets the threshold to 8.
// ----------------------------------------------------------------------------
`include "hamming_near_duplicate_tile_table_macros.svh"

module hamming_near_duplicate_tile_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [hndt_pkg::TILE_W-1:0]         tile_bits,
    input  logic                                cfg_write,
    input  logic [hndt_pkg::THRESH_W-1:0]       cfg_data,
    output logic                                done,
    output logic                                is_new,
    output logic [hndt_pkg::SLOT_W-1:0]         slot,
    output logic [hndt_pkg::DIST_W-1:0]         match_distance,
    output logic [hndt_pkg::UCOUNT_W-1:0]       unique_count,
    output logic                                table_full
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_DECIDE = 2'b10
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [hndt_pkg::THRESH_W-1:0]     thresh_reg;
    logic [hndt_pkg::TILE_W-1:0]       tile_reg;
    logic                              done_reg;
    logic                              is_new_reg;
    logic                              is_new_next;
    logic [hndt_pkg::SLOT_W-1:0]       slot_reg;
    logic [hndt_pkg::SLOT_W-1:0]       slot_next;
    logic [hndt_pkg::DIST_W-1:0]       dist_reg;
    logic [hndt_pkg::DIST_W-1:0]       dist_next;
    logic [hndt_pkg::UCOUNT_W-1:0]     ucount_reg;
    logic                              full_reg;
    logic                              full_next;

    logic                              accept;
    logic                              deciding;
    hndt_pkg::cell_ctl_t               ctl;
    logic [TABLE_DEPTH:0]              hit_chain;
    logic [TABLE_DEPTH-1:0]            first_hit;
    logic [hndt_pkg::DIST_W-1:0]       cell_dist [TABLE_DEPTH];
    logic [CNT_W-1:0]                  match_idx;
    logic [hndt_pkg::DIST_W-1:0]       match_dist;
    logic                              any_hit;
    logic [CNT_W+hndt_pkg::SLOT_W-1:0]   slot_ext;
    logic [CNT_W+hndt_pkg::UCOUNT_W-1:0] ucount_ext;

    assign deciding    = (state_reg == ST_DECIDE);
    assign busy        = deciding;
    assign accept      = start && !busy;
    assign ctl.capture = accept;
    assign ctl.append  = deciding && !any_hit;

    assign hit_chain[0] = 1'b0;
    assign any_hit      = hit_chain[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        hndt_cell #(
            .CELL_INDEX (g),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk            (clk),
            .ctl            (ctl),
            .probe_tile     (tile_bits),
            .store_tile     (tile_reg),
            .stored_count   (count_reg),
            .threshold      (thresh_reg),
            .hit_before_in  (hit_chain[g]),
            .hit_before_out (hit_chain[g+1]),
            .first_hit      (first_hit[g]),
            .distance       (cell_dist[g])
        );
    end

    // At most one cell flags the first hit, so an OR of the gated values
    // selects its slot and distance.
    always_comb
    begin
        match_idx  = '0;
        match_dist = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (first_hit[i])
            begin
                match_idx  = match_idx | CNT_W'(i);
                match_dist = match_dist | cell_dist[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        is_new_next = 1'b0;
        dist_next   = '0;
        full_next   = 1'b0;
        slot_ext    = '0;
        if (any_hit)
        begin
            slot_ext  = {{hndt_pkg::SLOT_W{1'b0}}, match_idx};
            dist_next = match_dist;
        end
        else if (count_reg < DEPTH_COUNT)
        begin
            slot_ext    = {{hndt_pkg::SLOT_W{1'b0}}, count_reg};
            count_next  = count_reg + CNT_W'(1);
            is_new_next = 1'b1;
        end
        else
        begin
            full_next = 1'b1;
        end
        slot_next  = slot_ext[hndt_pkg::SLOT_W-1:0];
        ucount_ext = {{hndt_pkg::UCOUNT_W{1'b0}}, count_next};
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_DECIDE : ST_IDLE;
            ST_DECIDE: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            thresh_reg <= hndt_pkg::THRESH_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= deciding;
            if (deciding)
            begin
                count_reg <= count_next;
            end
            if (cfg_write)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tile_reg <= tile_bits;
        end
        if (deciding)
        begin
            is_new_reg <= is_new_next;
            slot_reg   <= slot_next;
            dist_reg   <= dist_next;
            ucount_reg <= ucount_ext[hndt_pkg::UCOUNT_W-1:0];
            full_reg   <= full_next;
        end
    end

    assign done           = done_reg;
    assign is_new         = is_new_reg;
    assign slot           = slot_reg;
    assign match_distance = dist_reg;
    assign unique_count   = ucount_reg;
    assign table_full     = full_reg;

    `HNDT_ASSERT_NEXT(a_accept_decides, accept, busy && !done, "accepted tile did not enter decide")
    `HNDT_ASSERT_NEXT(a_decide_reports, deciding, done && !busy, "decide cycle gave no result")
    `HNDT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= DEPTH_COUNT, "fill count beyond depth")
    `HNDT_ASSERT_SAME(a_first_hit_unique, deciding, $onehot0(first_hit), "several first-hit cells")
    `HNDT_ASSERT_SAME(a_full_result, done && table_full, !is_new && (match_distance == '0), "bad full result")

endmodule

// ===== src/hndt_cell.sv =====
// ----------------------------------------------------------------------------
// Tile table cell
// Holds one stored tile, latches its distance to the incoming tile and takes
// part in the first-match priority chain toward higher slots.
// ----------------------------------------------------------------------------
module hndt_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 7
) (
    input  logic                            clk,
    input  hndt_pkg::cell_ctl_t             ctl,
    input  logic [hndt_pkg::TILE_W-1:0]     probe_tile,
    input  logic [hndt_pkg::TILE_W-1:0]     store_tile,
    input  logic [CNT_W-1:0]                stored_count,
    input  logic [hndt_pkg::THRESH_W-1:0]   threshold,
    input  logic                            hit_before_in,
    output logic                            hit_before_out,
    output logic                            first_hit,
    output logic [hndt_pkg::DIST_W-1:0]     distance
);

    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(CELL_INDEX);

    logic [hndt_pkg::TILE_W-1:0] tile_reg;
    logic [hndt_pkg::DIST_W-1:0] dist_reg;
    logic                        valid;
    logic                        hit;

    always_ff @(posedge clk)
    begin
        if (ctl.append && (stored_count == MY_SLOT))
        begin
            tile_reg <= store_tile;
        end
        if (ctl.capture)
        begin
            dist_reg <= hndt_pkg::tile_distance(probe_tile, tile_reg);
        end
    end

    // Only slots below the fill count hold a real tile.
    assign valid          = (MY_SLOT < stored_count);
    assign hit            = valid && (dist_reg < threshold);
    assign first_hit      = hit && !hit_before_in;
    assign hit_before_out = hit || hit_before_in;
    assign distance       = dist_reg;

endmodule

// ===== sim/tb_hamming_near_duplicate_tile_table.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Near-duplicate tile table testbench
// Sends 8x8 tiles through the start/busy handshake with random gaps, keeps its
// own copy of the tile table and threshold, and checks every done strobe
// against the expected match, append or drop verdict.
// ----------------------------------------------------------------------------
module tb_hamming_near_duplicate_tile_table;

    localparam int TILE_W   = hndt_pkg::TILE_W;
    localparam int SLOT_W   = hndt_pkg::SLOT_W;
    localparam int DIST_W   = hndt_pkg::DIST_W;
    localparam int UCOUNT_W = hndt_pkg::UCOUNT_W;
    localparam int THRESH_W = hndt_pkg::THRESH_W;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic                is_new;
        logic [SLOT_W-1:0]   slot;
        logic [DIST_W-1:0]   bit_diff;
        logic [UCOUNT_W-1:0] count;
        logic                full;
    } tile_verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [TILE_W-1:0]     tile_bits;
    logic                  cfg_write;
    logic [THRESH_W-1:0]   cfg_data;
    logic                  done;
    logic                  is_new;
    logic [SLOT_W-1:0]     slot;
    logic [DIST_W-1:0]     match_distance;
    logic [UCOUNT_W-1:0]   unique_count;
    logic                  table_full;

    // Shadow copy of the table and its threshold.
    logic [TILE_W-1:0]     model_tiles [DEPTH];
    int unsigned           model_count;
    logic [THRESH_W-1:0]   model_threshold;

    tile_verdict_t         expected_verdicts [$];
    tile_verdict_t         want_v;
    tile_verdict_t         got_v;

    int unsigned           fail_count;
    int unsigned           tiles_sent;
    int unsigned           new_count;
    int unsigned           match_count;
    int unsigned           drop_count;
    int unsigned           threshold_writes;
    int unsigned           burst_left;

    hamming_near_duplicate_tile_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .tile_bits      (tile_bits),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .done           (done),
        .is_new         (is_new),
        .slot           (slot),
        .match_distance (match_distance),
        .unique_count   (unique_count),
        .table_full     (table_full)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("hamming_near_duplicate_tile_table verification failed");
        $finish;
    end

    function automatic int unsigned bit_distance(input logic [TILE_W-1:0] a,
                                                 input logic [TILE_W-1:0] b);
        logic [TILE_W-1:0] x;
        int unsigned       n;
        x = a ^ b;
        n = 0;
        for (int i = 0; i < TILE_W; i++)
        begin
            n += x[i];
        end
        return n;
    endfunction

    // Lowest stored slot within the threshold wins; otherwise append or drop.
    function automatic tile_verdict_t predict_verdict(input logic [TILE_W-1:0] t);
        tile_verdict_t v;
        int unsigned   d;
        bit            hit;
        v   = '0;
        hit = 1'b0;
        for (int unsigned j = 0; j < model_count && !hit; j++)
        begin
            d = bit_distance(t, model_tiles[j]);
            if (d < model_threshold)
            begin
                hit        = 1'b1;
                v.slot     = j[SLOT_W-1:0];
                v.bit_diff = d[DIST_W-1:0];
            end
        end
        if (hit)
        begin
            match_count++;
        end
        else if (model_count < DEPTH)
        begin
            model_tiles[model_count] = t;
            v.slot   = model_count[SLOT_W-1:0];
            v.is_new = 1'b1;
            model_count++;
            new_count++;
        end
        else
        begin
            v.full = 1'b1;
            drop_count++;
        end
        v.count = model_count[UCOUNT_W-1:0];
        return v;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if (r < 4)
        begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // Start stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_tile(input logic [TILE_W-1:0] t);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        tile_bits <= t;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        expected_verdicts.push_back(predict_verdict(t));
        tiles_sent++;
    endtask

    task automatic drain_results();
        int unsigned waited;
        waited = 0;
        while (expected_verdicts.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [THRESH_W-1:0] thr);
        @(negedge clk);
        start <= 1'b0;
        drain_results();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= thr;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= THRESH_W'($urandom);
        model_threshold = thr;
        threshold_writes++;
    endtask

    function automatic logic [TILE_W-1:0] random_tile();
        return {$urandom, $urandom};
    endfunction

    // Mostly perturbed copies of stored tiles, with flip counts straddling the
    // threshold; the rest are fresh or degenerate tiles.
    function automatic logic [TILE_W-1:0] make_tile();
        logic [TILE_W-1:0] t;
        int unsigned       r;
        int unsigned       lim;
        r = $urandom_range(0, 99);
        if (model_count == 0 || r < 10)
            return random_tile();
        if (r < 13)
            return (r[0]) ? {TILE_W{1'b1}} : {TILE_W{1'b0}};
        t   = model_tiles[$urandom_range(0, model_count - 1)];
        lim = (model_threshold + 2 > TILE_W) ? TILE_W : model_threshold + 2;
        repeat ($urandom_range(0, lim))
        begin
            r    = $urandom_range(0, TILE_W - 1);
            t[r] = ~t[r];
        end
        return t;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            got_v = '{is_new, slot, match_distance, unique_count, table_full};
            if (expected_verdicts.size() == 0)
            begin
                report_failure("Result strobe with no tile outstanding.");
            end
            else
            begin
                want_v = expected_verdicts.pop_front();
                if (got_v.is_new !== want_v.is_new || got_v.slot !== want_v.slot ||
                    got_v.bit_diff !== want_v.bit_diff || got_v.count !== want_v.count ||
                    got_v.full !== want_v.full)
                begin
                    report_failure($sformatf(
                        {"Mismatch: expected new=%0d slot=%0d dist=%0d count=%0d full=%0d,",
                         " got new=%0d slot=%0d dist=%0d count=%0d full=%0d"},
                        want_v.is_new, want_v.slot, want_v.bit_diff, want_v.count,
                        want_v.full, got_v.is_new, got_v.slot, got_v.bit_diff,
                        got_v.count, got_v.full));
                end
            end
        end
    end

    task automatic test_default_threshold();
        send_tile({TILE_W{1'b0}});
        send_tile({TILE_W{1'b1}});
        send_tile(64'h0000_0000_0000_0007);
        send_tile(64'h0000_0000_0000_007F);
        send_tile(64'h0000_0000_0000_00FF);
        send_tile(64'h8000_0000_0000_0001);
    endtask

    task automatic test_threshold_zero();
        set_threshold(7'd0);
        send_tile({TILE_W{1'b0}});
        send_tile({TILE_W{1'b1}});
        send_tile({TILE_W{1'b0}});
    endtask

    task automatic test_threshold_saturated();
        set_threshold(7'd127);
        send_tile(random_tile());
        send_tile({TILE_W{1'b1}});
        set_threshold(7'd65);
        send_tile({TILE_W{1'b1}});
        set_threshold(7'd64);
        send_tile({TILE_W{1'b1}});
        send_tile(64'hFFFF_FFFF_0000_0000);
    endtask

    task automatic test_exact_match();
        set_threshold(7'd1);
        send_tile(64'h0000_0000_0000_00FF);
        send_tile(64'h0000_0000_0000_00FE);
        send_tile(64'hA5A5_5A5A_F00F_0FF0);
        send_tile(64'hA5A5_5A5A_F00F_0FF0);
    endtask

    // The zero-threshold phase fills the table, so later phases see drops.
    task automatic test_random_traffic();
        logic [THRESH_W-1:0] phase_thr [10];
        phase_thr = '{7'd8, 7'd20, 7'd1, 7'd33, 7'd0, 7'd64, 7'd65, 7'd127,
                      7'd0, 7'd8};
        phase_thr[8] = THRESH_W'($urandom_range(2, 40));
        foreach (phase_thr[p])
        begin
            set_threshold(phase_thr[p]);
            repeat (150) send_tile(make_tile());
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        tile_bits        = '0;
        cfg_write        = 1'b0;
        cfg_data         = '0;
        model_count      = 0;
        model_threshold  = hndt_pkg::THRESH_RESET;
        fail_count       = 0;
        tiles_sent       = 0;
        new_count        = 0;
        match_count      = 0;
        drop_count       = 0;
        threshold_writes = 0;
        burst_left       = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_threshold();
        test_threshold_zero();
        test_threshold_saturated();
        test_exact_match();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        drain_results();
        while (expected_verdicts.size() != 0)
        begin
            void'(expected_verdicts.pop_front());
            report_failure("Tile result never arrived.");
        end

        $display("Sent %0d tiles over %0d threshold settings: %0d appended, %0d matched,",
                 tiles_sent, threshold_writes, new_count, match_count);
        $display("%0d dropped on a full table; %0d mismatches.", drop_count, fail_count);
        if (fail_count == 0)
        begin
            $display("hamming_near_duplicate_tile_table verification clean");
        end
        else
        begin
            $display("hamming_near_duplicate_tile_table verification failed");
        end
        $finish;
    end

endmodule
